[hdl/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants of the SHA-256 digest block: the message and
// digest transaction structs, the initial hash words and the round constants.
// ----------------------------------------------------------------------------
package sha_pkg;

  // One message word transaction.
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } msg_t;

  // One digest word transaction.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_end;
  } digest_t;

  localparam logic [31:0] SHA_MARKER = 32'h8000_0000;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

[hdl/sha256_message_digest.sv]
// ----------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 over a byte message delivered as big-endian 32-bit words. A single
// round unit runs 64 times per 16-word block; padding and the bit length are
// generated one word per cycle after the last message word, pausing while a full block is compressed.
// ----------------------------------------------------------------------------
// A word that completes a block starts a compression: 64 rounds in the shared
// round unit (ST_ROUND), then one hash update (ST_UPDATE); msg_ready is low
// meanwhile, so no new message word is taken until the block is back in ST_IDLE.
// The last word adds padding words and one or two compressions,
// then 8 digest transactions, one per cycle while digest_ready is high.
// Reset (rst, synchronous) loads the initial hash and clears the byte count.
module sha256_message_digest (
  input  logic             clk,
  input  logic             rst,
  input  logic             msg_valid,
  output logic             msg_ready,
  input  sha_pkg::msg_t    msg,
  output logic             digest_valid,
  input  logic             digest_ready,
  output sha_pkg::digest_t digest
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } state_t;

  state_t      state;
  logic [31:0] hash [8];
  logic [31:0] work [8];
  logic [31:0] sched [16];
  logic [3:0]  pos;
  logic [60:0] msg_bytes;
  logic [5:0]  round_cnt;
  logic [2:0]  out_idx;
  logic        padding;
  logic        marker_pending;
  logic        hi_done;
  logic        lo_done;

  logic [2:0]  nb_sat;
  logic [2:0]  byte_add;
  logic        push_en;
  logic [31:0] push_word;
  logic [31:0] len_hi;
  logic [31:0] len_lo;
  logic [31:0] sched_new;
  logic [31:0] work_next [8];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] keep_mask(input logic [1:0] nb);
    case (nb)
      2'd0:    keep_mask = 32'h0000_0000;
      2'd1:    keep_mask = 32'hff00_0000;
      2'd2:    keep_mask = 32'hffff_0000;
      default: keep_mask = 32'hffff_ff00;
    endcase
  endfunction

  // Saturated byte count of the incoming word.
  assign nb_sat   = (msg.valid_bytes > 3'd4) ? 3'd4 : msg.valid_bytes;
  assign byte_add = msg.last_word ? nb_sat : 3'd4;
  assign len_hi   = msg_bytes[60:29];
  assign len_lo   = {msg_bytes[28:0], 3'b000};

  // Word pushed into the schedule window this cycle.
  always_comb begin
    push_en   = 1'b0;
    push_word = '0;
    unique case (state)
      ST_IDLE: begin
        if (msg_valid) begin
          push_en = 1'b1;
          if (!msg.last_word || nb_sat == 3'd4) begin
            push_word = msg.data_word;
          end else begin
            push_word = (msg.data_word & keep_mask(nb_sat[1:0])) |
                        (SHA_MARKER >> {nb_sat[1:0], 3'b000});
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (marker_pending) begin
          push_word = SHA_MARKER;
        end else if (hi_done) begin
          push_word = len_lo;
        end else if (pos == 4'd14) begin
          push_word = len_hi;
        end
      end
      default: ;
    endcase
  end

  // Shared round unit: one SHA-256 round and one schedule word per cycle in ST_ROUND.
  always_comb begin
    logic [31:0] s0, s1, big0, big1, ch, maj, t1, t2;
    s0   = rotr(sched[1], 7) ^ rotr(sched[1], 18) ^ (sched[1] >> 3);
    s1   = rotr(sched[14], 17) ^ rotr(sched[14], 19) ^ (sched[14] >> 10);
    sched_new = sched[0] + s0 + sched[9] + s1;
    big1 = rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25);
    ch   = (work[4] & work[5]) ^ (~work[4] & work[6]);
    t1   = work[7] + big1 + ch + SHA_K[round_cnt] + sched[0];
    big0 = rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22);
    maj  = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    t2   = big0 + maj;
    work_next[0] = t1 + t2;
    work_next[1] = work[0];
    work_next[2] = work[1];
    work_next[3] = work[2];
    work_next[4] = work[3] + t1;
    work_next[5] = work[4];
    work_next[6] = work[5];
    work_next[7] = work[6];
  end

  // Sequencer, state and hash registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pos            <= '0;
      msg_bytes      <= '0;
      round_cnt      <= '0;
      out_idx        <= '0;
      padding        <= 1'b0;
      marker_pending <= 1'b0;
      hi_done        <= 1'b0;
      lo_done        <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= SHA_IV[i];
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (msg_valid) begin
            msg_bytes <= msg_bytes + 61'(byte_add);
            if (msg.last_word) begin
              padding        <= 1'b1;
              marker_pending <= (nb_sat == 3'd4);
              hi_done        <= 1'b0;
              lo_done        <= 1'b0;
              // A last word that fills the block compresses first.
              if (pos != 4'd15) begin
                state <= ST_PAD;
              end
            end
          end
        end
        ST_PAD: begin
          if (marker_pending) begin
            marker_pending <= 1'b0;
          end else if (hi_done) begin
            lo_done <= 1'b1;
          end else if (pos == 4'd14) begin
            hi_done <= 1'b1;
          end
        end
        ST_ROUND: begin
          for (int i = 0; i < 8; i++) begin
            work[i] <= work_next[i];
          end
          round_cnt <= round_cnt + 6'd1;
          if (round_cnt == 6'd63) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + work[i];
          end
          if (!padding) begin
            state <= ST_IDLE;
          end else if (lo_done) begin
            out_idx <= '0;
            state   <= ST_OUT;
          end else begin
            state <= ST_PAD;
          end
        end
        ST_OUT: begin
          if (digest_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                hash[i] <= SHA_IV[i];
              end
              msg_bytes <= '0;
              padding   <= 1'b0;
              state     <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase

      // A push that fills the block starts a compression.
      if (push_en) begin
        pos <= pos + 4'd1;
        if (pos == 4'd15) begin
          for (int i = 0; i < 8; i++) begin
            work[i] <= hash[i];
          end
          round_cnt <= '0;
          state     <= ST_ROUND;
        end
      end
    end
  end

  // Schedule window: loads message words, then slides once per round.
  always_ff @(posedge clk) begin
    if (push_en || state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[15] <= push_en ? push_word : sched_new;
    end
  end

  assign msg_ready           = (state == ST_IDLE);
  assign digest_valid        = (state == ST_OUT);
  assign digest.digest_word  = hash[out_idx];
  assign digest.digest_index = out_idx;
  assign digest.digest_end   = (out_idx == 3'd7);

endmodule

[hdl/sha_chk.sv]
// ----------------------------------------------------------------------------
// sha_chk
// Port-level checks of the SHA-256 digest block, bound to the top level.
// ----------------------------------------------------------------------------
module sha_chk (
  input logic             clk,
  input logic             rst,
  input logic             msg_valid,
  input logic             msg_ready,
  input sha_pkg::msg_t    msg,
  input logic             digest_valid,
  input logic             digest_ready,
  input sha_pkg::digest_t digest
);
  import sha_pkg::*;

  // No message transaction is taken while a digest is being delivered.
  a_no_input_during_output: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> !msg_ready)
    else $error("message accepted while digest pending");

  // A stalled digest word holds its value.
  a_digest_hold: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_ready |=> digest_valid && $stable(digest))
    else $error("digest changed while stalled");

  // Digest words follow each other in index order without gaps.
  a_digest_sequence: assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && !digest.digest_end |=>
      digest_valid && digest.digest_index == $past(digest.digest_index) + 3'd1)
    else $error("digest word sequence broken");

  // The end mark sits on the eighth word and only there.
  a_digest_end: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> digest.digest_end == (digest.digest_index == 3'd7))
    else $error("digest end mark misplaced");

  // After the last digest word the block is ready for a new message.
  a_ready_after_end: assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && digest.digest_end |=> msg_ready && !digest_valid)
    else $error("block not idle after digest");

endmodule

bind sha256_message_digest sha_chk u_sha_chk (.*);

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sha256_message_digest. Messages are streamed in as
// word transactions with bursty input timing and a stalling digest receiver.
// A scoreboard class runs SHA-256 alongside the block and compares every
// digest transaction against the words it expects, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import sha_pkg::*;

  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned RANDOM_WORDS   = 260;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned HOLD_START     = 800;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam logic [31:0] PAD_MARKER     = 32'h8000_0000;

  // Initial hash words and round constants of SHA-256.
  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Receiver stall patterns.
  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_PULSE,
    RX_MOSTLY
  } rx_mode_e;

  // Running SHA-256 of the message stream and the digest words it expects.
  class digest_scoreboard;
    logic [31:0]  hash_words [8];
    logic [31:0]  block_words [16];
    int unsigned  fill;
    logic [60:0]  byte_count;
    digest_t      expected_q [$];
    int unsigned  error_count;

    function new();
      error_count = 0;
      restart();
    endfunction

    function void restart();
      foreach (hash_words[k]) hash_words[k] = INIT_HASH[k];
      foreach (block_words[k]) block_words[k] = '0;
      fill = 0;
      byte_count = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of the buffered block into the hash words.
    function void compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = block_words[i];
      for (int i = 16; i < 64; i++) begin
        s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
      e = hash_words[4]; f = hash_words[5]; g = hash_words[6]; h = hash_words[7];
      for (int i = 0; i < 64; i++) begin
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + ROUND_K[i] + w[i];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
      hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
    endfunction

    function void absorb_word(logic [31:0] w);
      block_words[fill] = w;
      fill = (fill + 1) % 16;
      if (fill == 0) compress_block();
    endfunction

    // Accepted message transaction; a last word closes the message.
    function void note_message(msg_t m);
      int unsigned nbytes;
      logic [31:0] keep;
      logic [63:0] bit_length;
      digest_t     dw;
      if (!m.last_word) begin
        byte_count += 61'd4;
        absorb_word(m.data_word);
        return;
      end
      nbytes = (m.valid_bytes > 3'd4) ? 4 : m.valid_bytes;
      byte_count += 61'(nbytes);
      if (nbytes == 4) begin
        absorb_word(m.data_word);
        absorb_word(PAD_MARKER);
      end else begin
        keep = (nbytes == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nbytes));
        absorb_word((m.data_word & keep) | (PAD_MARKER >> (8 * nbytes)));
      end
      while (fill != 14) absorb_word(32'h0);
      bit_length = {byte_count, 3'b000};
      absorb_word(bit_length[63:32]);
      absorb_word(bit_length[31:0]);
      for (int k = 0; k < 8; k++) begin
        dw.digest_word  = hash_words[k];
        dw.digest_index = 3'(k);
        dw.digest_end   = (k == 7);
        expected_q.push_back(dw);
      end
      restart();
    endfunction

    task report(string what);
      error_count++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Accepted digest transaction against the oldest expected word.
    task check_digest(digest_t got);
      digest_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected digest word %08h index %0d",
                         got.digest_word, got.digest_index));
        return;
      end
      want = expected_q.pop_front();
      if (got.digest_word !== want.digest_word)
        report($sformatf("digest_word %08h, expected %08h (index %0d)",
                         got.digest_word, want.digest_word, want.digest_index));
      if (got.digest_index !== want.digest_index)
        report($sformatf("digest_index %0d, expected %0d",
                         got.digest_index, want.digest_index));
      if (got.digest_end !== want.digest_end)
        report($sformatf("digest_end %0b, expected %0b (index %0d)",
                         got.digest_end, want.digest_end, want.digest_index));
    endtask

    task check_leftover();
      if (expected_q.size() != 0)
        report($sformatf("%0d digest words never arrived", expected_q.size()));
    endtask

    function int unsigned pending_count();
      return expected_q.size();
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    msg_valid = 1'b0;
  logic    msg_ready;
  msg_t    msg = '0;
  logic    digest_valid;
  logic    digest_ready = 1'b0;
  digest_t digest;

  digest_scoreboard sb = new();
  int unsigned      burst_left = 0;
  int unsigned      words_sent = 0;
  int unsigned      cycle_count = 0;

  sha256_message_digest dut (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_ready    (msg_ready),
    .msg          (msg),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Both channels are sampled on the edge at which a transaction completes.
  always @(posedge clk) begin
    if (!rst) begin
      if (msg_valid && msg_ready) sb.note_message(msg);
      if (digest_valid && digest_ready) sb.check_digest(digest);
    end
  end

  // Run limit.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sha256_message_digest test failed");
    $finish;
  end

  // Digest receiver: changing stall patterns plus one long hold-off.
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned seg_left;
    int unsigned rx_cycles;
    bit          hold_done;
    mode = RX_OPEN;
    seg_left = 0;
    rx_cycles = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (!hold_done && rx_cycles >= HOLD_START) begin
        // Long hold-off while the sender keeps offering words.
        digest_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          seg_left = $urandom_range(16, 96);
        end
        seg_left--;
        case (mode)
          RX_OPEN:   digest_ready <= 1'b1;
          RX_COIN:   digest_ready <= 1'($urandom_range(0, 1));
          RX_PULSE:  digest_ready <= (rx_cycles % 4 == 0);
          default:   digest_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic msg_t make_word(logic [31:0] data, logic [2:0] nbytes, logic last);
    msg_t m;
    m.data_word   = data;
    m.valid_bytes = nbytes;
    m.last_word   = last;
    return m;
  endfunction

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word transaction and hold it until accepted; gaps come between bursts.
  task automatic send_word(input msg_t m);
    msg <= m;
    msg_valid <= 1'b1;
    do @(posedge clk); while (!msg_ready);
    words_sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      msg_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(0, 10);
    end
  endtask

  // A message of random length; the last word has any valid_bytes code.
  task automatic send_random_message();
    int unsigned body;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) body = 0;
    else if (pick < 75) body = $urandom_range(1, 20);
    else if (pick < 95) body = $urandom_range(21, 40);
    else body = $urandom_range(41, 70);
    repeat (body) send_word(make_word(pick_data(), 3'($urandom_range(0, 7)), 1'b0));
    send_word(make_word(pick_data(), 3'($urandom_range(0, 7)), 1'b1));
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Empty message, with junk in the ignored bytes.
    send_word(make_word(32'hFFFF_FFFF, 3'd0, 1'b1));
    // One-word messages of 1 to 4 bytes.
    for (int n = 1; n <= 4; n++) send_word(make_word(32'hFFFF_FFFF, 3'(n), 1'b1));
    // Byte counts above 4 saturate to a full word.
    send_word(make_word(32'h0000_0000, 3'd5, 1'b1));
    send_word(make_word(32'h1234_5678, 3'd6, 1'b1));
    send_word(make_word(32'hFFFF_FFFF, 3'd7, 1'b1));
    // A body word takes all four bytes whatever its byte count says.
    send_word(make_word(32'h0000_0000, 3'd0, 1'b0));
    send_word(make_word(32'hFFFF_FFFF, 3'd3, 1'b1));
    // Fourteen words: the length no longer fits and a second block follows.
    for (int k = 0; k < 13; k++)
      send_word(make_word((k % 2) ? 32'hFFFF_FFFF : 32'h0, 3'(k % 8), 1'b0));
    send_word(make_word(32'hA5A5_5A5A, 3'd4, 1'b1));

    while (words_sent < RANDOM_WORDS) send_random_message();
    msg_valid <= 1'b0;

    // One edge lets the scoreboard note the final transaction first.
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_leftover();
    if (sb.error_count == 0) begin
      $display("sha256_message_digest test passed");
    end else begin
      $display("sha256_message_digest test failed");
    end
    $finish;
  end

endmodule
